[rtl/ffha_pkg.sv]
// shared types and constants for the first-fit heap allocator
// used by ffha_ctrl, ffha_datapath and first_fit_heap_allocator
package ffha_pkg;

  localparam int HEAP_BYTES = 4096;
  localparam int IDX_W      = $clog2(HEAP_BYTES);  // header store index
  localparam int OFF_W      = IDX_W + 1;           // offset, top bit set means null
  localparam int WA_W       = OFF_W + 1;           // offset sums before range check
  localparam int REQ_W      = 19;                  // rounded request plus header
  localparam int CNT_W      = 9;

  localparam logic [OFF_W-1:0] NIL       = OFF_W'(HEAP_BYTES);
  localparam logic [4:0]       MIN_BLOCK = 5'd16;
  localparam logic [3:0]       HDR_BYTES = 4'd8;

  // request modes
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_INIT  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_SIZE  = 2'd1;
  localparam logic [1:0] CFG_OWNER = 2'd2;
  localparam logic [1:0] CFG_ALIGN = 2'd3;

  // micro-operations issued by the controller
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_START,
    CMD_WALK_RD,
    CMD_ALLOC_EVAL,
    CMD_SPLIT1,
    CMD_SPLIT2,
    CMD_TAKE,
    CMD_FAIL,
    CMD_FREE_CHK,
    CMD_FREE_HDR,
    CMD_MERGE1,
    CMD_MERGE2,
    CMD_PREV_RD,
    CMD_PREV_MERGE,
    CMD_PUSH1,
    CMD_PUSH2,
    CMD_QUERY_EVAL,
    CMD_INIT,
    CMD_DONE
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       walk_ok;
    logic       fit;
    logic       split;
    logic       free_in;
    logic       nx_free;
    logic       prev_free;
    logic       merged;
    logic       out_full;
  } status_t;

endpackage

[rtl/ffha_ctrl.sv]
// sequencing state machine for the first-fit heap allocator
// depends on ffha_pkg for command and status types
module ffha_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ffha_pkg::status_t status,
  output ffha_pkg::cmd_t   cmd
);

  typedef enum logic [19:0] {
    S_IDLE     = 20'h00001,
    S_DISPATCH = 20'h00002,
    S_A_CHK    = 20'h00004,
    S_A_EVAL   = 20'h00008,
    S_A_SPLIT1 = 20'h00010,
    S_A_SPLIT2 = 20'h00020,
    S_A_TAKE   = 20'h00040,
    S_A_FAIL   = 20'h00080,
    S_F_CHK    = 20'h00100,
    S_F_HDR    = 20'h00200,
    S_F_NX     = 20'h00400,
    S_F_M1     = 20'h00800,
    S_F_M2     = 20'h01000,
    S_F_PRV    = 20'h02000,
    S_F_PE     = 20'h04000,
    S_F_P2     = 20'h08000,
    S_Q_CHK    = 20'h10000,
    S_Q_EVAL   = 20'h20000,
    S_INIT     = 20'h40000,
    S_DONE     = 20'h80000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = ffha_pkg::CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = ffha_pkg::CMD_START;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.mode)
          ffha_pkg::MODE_ALLOC: state_next = S_A_CHK;
          ffha_pkg::MODE_FREE:  state_next = S_F_CHK;
          ffha_pkg::MODE_QUERY: state_next = S_Q_CHK;
          default:              state_next = S_INIT;
        endcase
      end
      S_A_CHK: begin
        if (status.walk_ok) begin
          cmd        = ffha_pkg::CMD_WALK_RD;
          state_next = S_A_EVAL;
        end else begin
          state_next = S_A_FAIL;
        end
      end
      S_A_EVAL: begin
        cmd = ffha_pkg::CMD_ALLOC_EVAL;
        if (!status.fit)       state_next = S_A_CHK;
        else if (status.split) state_next = S_A_SPLIT1;
        else                   state_next = S_A_TAKE;
      end
      S_A_SPLIT1: begin
        cmd        = ffha_pkg::CMD_SPLIT1;
        state_next = S_A_SPLIT2;
      end
      S_A_SPLIT2: begin
        cmd        = ffha_pkg::CMD_SPLIT2;
        state_next = S_DONE;
      end
      S_A_TAKE: begin
        cmd        = ffha_pkg::CMD_TAKE;
        state_next = S_DONE;
      end
      S_A_FAIL: begin
        cmd        = ffha_pkg::CMD_FAIL;
        state_next = S_DONE;
      end
      S_F_CHK: begin
        cmd        = ffha_pkg::CMD_FREE_CHK;
        state_next = status.free_in ? S_F_HDR : S_DONE;
      end
      S_F_HDR: begin
        cmd        = ffha_pkg::CMD_FREE_HDR;
        state_next = S_F_NX;
      end
      S_F_NX: begin
        state_next = status.nx_free ? S_F_M1 : S_F_PRV;
      end
      S_F_M1: begin
        cmd        = ffha_pkg::CMD_MERGE1;
        state_next = S_F_M2;
      end
      S_F_M2: begin
        cmd        = ffha_pkg::CMD_MERGE2;
        state_next = S_F_PRV;
      end
      S_F_PRV: begin
        cmd        = ffha_pkg::CMD_PREV_RD;
        state_next = S_F_PE;
      end
      S_F_PE: begin
        priority if (status.prev_free) begin
          cmd        = ffha_pkg::CMD_PREV_MERGE;
          state_next = S_DONE;
        end else if (status.merged) begin
          state_next = S_DONE;
        end else begin
          cmd        = ffha_pkg::CMD_PUSH1;
          state_next = S_F_P2;
        end
      end
      S_F_P2: begin
        cmd        = ffha_pkg::CMD_PUSH2;
        state_next = S_DONE;
      end
      S_Q_CHK: begin
        if (status.walk_ok) begin
          cmd        = ffha_pkg::CMD_WALK_RD;
          state_next = S_Q_EVAL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_Q_EVAL: begin
        cmd        = ffha_pkg::CMD_QUERY_EVAL;
        state_next = S_Q_CHK;
      end
      S_INIT: begin
        cmd        = ffha_pkg::CMD_INIT;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!status.out_full) begin
          cmd        = ffha_pkg::CMD_DONE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/ffha_datapath.sv]
// header stores, list registers and result register of the heap allocator
// depends on ffha_pkg; driven by micro-operations from ffha_ctrl
module ffha_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [1:0]        mode,
  input  logic [15:0]       request_bytes,
  input  logic [31:0]       release_address,
  input  ffha_pkg::cmd_t    cmd,
  output ffha_pkg::status_t status,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              success,
  output logic [31:0]       granted_address,
  output logic [8:0]        free_blocks,
  output logic [12:0]       largest_free,
  output logic [12:0]       bytes_in_use
);

  localparam int OW = ffha_pkg::OFF_W;
  localparam int AW = ffha_pkg::WA_W;
  localparam int IW = ffha_pkg::IDX_W;
  localparam int RW = ffha_pkg::REQ_W;
  localparam int CW = ffha_pkg::CNT_W;

  // configuration
  logic [31:0] base_address;
  logic [12:0] heap_size;
  logic [15:0] owner_id;
  logic [3:0]  align_shift;

  // working registers
  logic [1:0]    mode_r;
  logic [RW-1:0] req;
  logic [OW-1:0] b, steps, blk, nf, pf, prev, nnf, npf, head, used;
  logic [AW-1:0] nx;
  logic          merged, head_hit, succ, free_in_r;
  logic [31:0]   addr;
  logic [CW-1:0] cnt;
  logic [OW-1:0] largest;

  // header stores
  logic [OW-1:0] len_mem   [ffha_pkg::HEAP_BYTES];
  logic          taken_mem [ffha_pkg::HEAP_BYTES];
  logic [15:0]   owner_mem [ffha_pkg::HEAP_BYTES];
  logic [OW-1:0] phys_mem  [ffha_pkg::HEAP_BYTES];
  logic [OW-1:0] after_mem [ffha_pkg::HEAP_BYTES];
  logic [OW-1:0] bef_mem   [ffha_pkg::HEAP_BYTES];

  logic [OW-1:0] q_len, q_phys, q_after, q_bef;
  logic          q_taken, rd_oor;
  logic [OW-1:0] r_len, r_phys, r_after, r_bef;
  logic          r_taken;

  logic          rd_en;
  logic [AW-1:0] rd_addr;

  logic          len_we, taken_we, owner_we, phys_we, after_we, bef_we;
  logic [AW-1:0] len_wa, taken_wa, owner_wa, phys_wa, after_wa, bef_wa;
  logic [OW-1:0] len_wd, phys_wd, after_wd, bef_wd;
  logic          taken_wd;

  // derived values
  logic [16:0]   hdr, amask;
  logic [RW-1:0] req_round, req_hdr, req_full;
  logic [OW-1:0] reg_end, blk2;
  logic [31:0]   off32;
  logic          free_in;
  logic [AW-1:0] nb, phys_a, merge_end, prev_end, nx_c;

  assign hdr   = (align_shift <= 4'd3) ? 17'(ffha_pkg::HDR_BYTES) : (17'd1 << align_shift);
  assign amask = (align_shift == 4'd0) ? 17'd0 : ((17'd1 << align_shift) - 17'd1);
  assign req_round = (RW'(request_bytes) + RW'(amask)) & ~RW'(amask);
  assign req_hdr   = req_round + RW'(hdr);
  assign req_full  = (req_hdr < RW'(ffha_pkg::MIN_BLOCK)) ? RW'(ffha_pkg::MIN_BLOCK) : req_hdr;

  assign reg_end = (heap_size < ffha_pkg::NIL) ? heap_size : ffha_pkg::NIL;
  assign off32   = release_address - base_address - 32'(hdr);
  assign free_in = off32 < 32'(reg_end);

  assign r_len   = rd_oor ? '0 : q_len;
  assign r_phys  = rd_oor ? '0 : q_phys;
  assign r_after = rd_oor ? '0 : q_after;
  assign r_bef   = rd_oor ? '0 : q_bef;
  assign r_taken = rd_oor ? 1'b0 : q_taken;

  assign nb        = AW'(b) + AW'(req[OW-1:0]);
  assign phys_a    = AW'(b) + AW'(blk);
  assign merge_end = AW'(b) + AW'(blk);
  assign blk2      = blk + r_len;
  assign prev_end  = AW'(prev) + AW'(blk2);
  assign nx_c      = AW'(b) + AW'(r_len);

  assign status.mode      = mode_r;
  assign status.walk_ok   = !b[OW-1] && !steps[OW-1];
  assign status.fit       = (RW'(r_len) >= req);
  assign status.split     = ((RW+1)'(req) + (RW+1)'(ffha_pkg::MIN_BLOCK)) < (RW+1)'(r_len);
  assign status.free_in   = free_in_r;
  assign status.nx_free   = (nx < AW'(reg_end)) && !r_taken;
  assign status.prev_free = !prev[OW-1] && !r_taken;
  assign status.merged    = merged;
  assign status.out_full  = out_valid && !out_ready;

  // read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(b);
    unique case (cmd)
      ffha_pkg::CMD_WALK_RD,
      ffha_pkg::CMD_FREE_CHK: rd_en = 1'b1;
      ffha_pkg::CMD_FREE_HDR: begin
        rd_en   = 1'b1;
        rd_addr = nx_c;
      end
      ffha_pkg::CMD_PREV_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(prev);
      end
      default: rd_en = 1'b0;
    endcase
  end

  // write ports, one per store
  always_comb begin
    len_we = 1'b0;   len_wa = AW'(b);   len_wd = '0;
    taken_we = 1'b0; taken_wa = AW'(b); taken_wd = 1'b0;
    owner_we = 1'b0; owner_wa = AW'(b);
    phys_we = 1'b0;  phys_wa = AW'(b);  phys_wd = '0;
    after_we = 1'b0; after_wa = AW'(b); after_wd = '0;
    bef_we = 1'b0;   bef_wa = AW'(b);   bef_wd = '0;
    unique case (cmd)
      ffha_pkg::CMD_SPLIT1: begin
        len_we = 1'b1;   len_wd = req[OW-1:0];
        after_we = 1'b1; after_wa = nb; after_wd = nf;
        bef_we = 1'b1;   bef_wa = nb;   bef_wd = pf;
        phys_we = 1'b1;  phys_wa = nb;  phys_wd = b;
        taken_we = 1'b1; taken_wa = nb; taken_wd = 1'b0;
        owner_we = 1'b1; owner_wa = nb;
      end
      ffha_pkg::CMD_SPLIT2: begin
        len_we = 1'b1;   len_wa = nb;   len_wd = blk - req[OW-1:0];
        bef_we = !nf[OW-1]; bef_wa = AW'(nf); bef_wd = nb[OW-1:0];
        after_we = (head != b) && !pf[OW-1];
        after_wa = AW'(pf); after_wd = nb[OW-1:0];
        phys_we = phys_a < AW'(reg_end); phys_wa = phys_a; phys_wd = nb[OW-1:0];
        taken_we = 1'b1; taken_wd = 1'b1;
        owner_we = 1'b1;
      end
      ffha_pkg::CMD_TAKE: begin
        after_we = (head != b) && !pf[OW-1];
        after_wa = AW'(pf); after_wd = nf;
        bef_we = !nf[OW-1]; bef_wa = AW'(nf); bef_wd = pf;
        taken_we = 1'b1; taken_wd = 1'b1;
        owner_we = 1'b1;
      end
      ffha_pkg::CMD_FREE_HDR: begin
        taken_we = 1'b1; taken_wd = 1'b0;
      end
      ffha_pkg::CMD_MERGE1: begin
        len_we = 1'b1;   len_wd = blk + r_len;
        after_we = 1'b1; after_wd = r_after;
        bef_we = 1'b1;   bef_wd = r_bef;
      end
      ffha_pkg::CMD_MERGE2: begin
        after_we = !head_hit && !npf[OW-1];
        after_wa = AW'(npf); after_wd = b;
        bef_we = !nnf[OW-1]; bef_wa = AW'(nnf); bef_wd = b;
        phys_we = merge_end < AW'(reg_end); phys_wa = merge_end; phys_wd = b;
      end
      ffha_pkg::CMD_PREV_MERGE: begin
        len_we = 1'b1; len_wa = AW'(prev); len_wd = blk2;
        after_we = merged && (head != b) && !npf[OW-1];
        after_wa = AW'(npf); after_wd = nnf;
        bef_we = merged && !nnf[OW-1]; bef_wa = AW'(nnf); bef_wd = npf;
        phys_we = prev_end < AW'(reg_end); phys_wa = prev_end; phys_wd = prev;
      end
      ffha_pkg::CMD_PUSH1: begin
        bef_we = 1'b1;   bef_wd = ffha_pkg::NIL;
        after_we = 1'b1; after_wd = head;
      end
      ffha_pkg::CMD_PUSH2: begin
        bef_we = !head[OW-1]; bef_wa = AW'(head); bef_wd = b;
      end
      ffha_pkg::CMD_INIT: begin
        len_we = 1'b1;   len_wa = '0;   len_wd = heap_size;
        taken_we = 1'b1; taken_wa = '0; taken_wd = 1'b0;
        owner_we = 1'b1; owner_wa = '0;
        phys_we = 1'b1;  phys_wa = '0;  phys_wd = ffha_pkg::NIL;
        after_we = 1'b1; after_wa = '0; after_wd = ffha_pkg::NIL;
        bef_we = 1'b1;   bef_wa = '0;   bef_wd = ffha_pkg::NIL;
      end
      default: len_we = 1'b0;
    endcase
  end

  // memories: writes beyond the store are dropped
  always_ff @(posedge clk) begin
    if (len_we && len_wa[AW-1:IW] == '0) len_mem[len_wa[IW-1:0]] <= len_wd;
    if (taken_we && taken_wa[AW-1:IW] == '0) taken_mem[taken_wa[IW-1:0]] <= taken_wd;
    if (owner_we && owner_wa[AW-1:IW] == '0) owner_mem[owner_wa[IW-1:0]] <= owner_id;
    if (phys_we && phys_wa[AW-1:IW] == '0) phys_mem[phys_wa[IW-1:0]] <= phys_wd;
    if (after_we && after_wa[AW-1:IW] == '0) after_mem[after_wa[IW-1:0]] <= after_wd;
    if (bef_we && bef_wa[AW-1:IW] == '0) bef_mem[bef_wa[IW-1:0]] <= bef_wd;
    if (rd_en) begin
      q_len   <= len_mem[rd_addr[IW-1:0]];
      q_taken <= taken_mem[rd_addr[IW-1:0]];
      q_phys  <= phys_mem[rd_addr[IW-1:0]];
      q_after <= after_mem[rd_addr[IW-1:0]];
      q_bef   <= bef_mem[rd_addr[IW-1:0]];
      rd_oor  <= rd_addr[AW-1:IW] != '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      heap_size    <= 13'(ffha_pkg::HEAP_BYTES);
      owner_id     <= '0;
      align_shift  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffha_pkg::CFG_BASE:  base_address <= cfg_data;
        ffha_pkg::CFG_SIZE:  heap_size    <= cfg_data[12:0];
        ffha_pkg::CFG_OWNER: owner_id     <= cfg_data[15:0];
        default:             align_shift  <= cfg_data[3:0];
      endcase
    end
  end

  // list head and byte total
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= ffha_pkg::NIL;
      used <= '0;
    end else begin
      unique case (cmd)
        ffha_pkg::CMD_SPLIT2: begin
          used <= used + req[OW-1:0];
          if (head == b) head <= nb[OW-1:0];
        end
        ffha_pkg::CMD_TAKE: begin
          used <= used + blk;
          if (head == b) head <= nf;
        end
        ffha_pkg::CMD_FREE_HDR: used <= used - r_len;
        ffha_pkg::CMD_MERGE1: if (AW'(head) == nx) head <= b;
        ffha_pkg::CMD_PREV_MERGE: if (merged && head == b) head <= nnf;
        ffha_pkg::CMD_PUSH2: head <= b;
        ffha_pkg::CMD_INIT: begin
          used <= '0;
          head <= '0;
        end
        default: head <= head;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd)
      ffha_pkg::CMD_START: begin
        mode_r    <= mode;
        req       <= req_full;
        b         <= (mode == ffha_pkg::MODE_FREE) ? off32[OW-1:0] : head;
        free_in_r <= free_in;
        steps     <= '0;
        cnt       <= '0;
        largest   <= '0;
        addr      <= '0;
        succ      <= 1'b1;
        merged    <= 1'b0;
      end
      ffha_pkg::CMD_ALLOC_EVAL: begin
        if (status.fit) begin
          blk <= r_len;
          nf  <= r_after;
          pf  <= r_bef;
        end else begin
          b     <= r_after;
          steps <= steps + 1'b1;
        end
      end
      ffha_pkg::CMD_SPLIT2,
      ffha_pkg::CMD_TAKE: addr <= base_address + 32'(b) + 32'(hdr);
      ffha_pkg::CMD_FAIL: begin
        succ <= 1'b0;
        addr <= '0;
      end
      ffha_pkg::CMD_FREE_CHK: if (!free_in_r) succ <= 1'b0;
      ffha_pkg::CMD_FREE_HDR: begin
        blk  <= r_len;
        prev <= r_phys;
        nx   <= nx_c;
      end
      ffha_pkg::CMD_MERGE1: begin
        nnf      <= r_after;
        npf      <= r_bef;
        blk      <= blk + r_len;
        merged   <= 1'b1;
        head_hit <= AW'(head) == nx;
      end
      ffha_pkg::CMD_QUERY_EVAL: begin
        if (cnt != '1) cnt <= cnt + 1'b1;
        if (r_len > largest) largest <= r_len;
        b     <= r_after;
        steps <= steps + 1'b1;
      end
      default: steps <= steps;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == ffha_pkg::CMD_DONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == ffha_pkg::CMD_DONE) begin
      success         <= succ;
      granted_address <= addr;
      free_blocks     <= cnt;
      largest_free    <= largest;
      bytes_in_use    <= used;
    end
  end

`ifndef NO_ASSERTIONS
  a_walk_keeps_head: assert property (@(posedge clk) disable iff (rst)
    (cmd == ffha_pkg::CMD_QUERY_EVAL || cmd == ffha_pkg::CMD_ALLOC_EVAL)
      |=> head == $past(head))
    else $error("free list head moved during a walk");
  a_done_shows: assert property (@(posedge clk) disable iff (rst)
    cmd == ffha_pkg::CMD_DONE |=> out_valid && success == $past(succ))
    else $error("result not presented after completion");
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !success) |-> granted_address == 32'd0)
    else $error("failed request carries an address");
`endif

endmodule

[rtl/first_fit_heap_allocator.sv]
// top level of the first-fit heap allocator
// depends on ffha_pkg, ffha_ctrl and ffha_datapath
//
// First-fit heap allocator over a region of up to 4096 bytes, with a doubly
// linked free list and coalescing on free. Each request (allocate, free,
// query, init) gives one result. Block headers live in six 4096-entry header
// stores with one shared read port, so while walking the list each header
// read is followed by an evaluation state before the next read. Allocate
// visits free blocks until one fits, with an extra step when the block is
// split; query visits the whole free list; free merges with free neighbours
// and skips all header updates when the address lies outside the region. A
// finished result sits in an output register and the block takes the next
// request when it returns to idle. The header stores are not cleared after
// reset: issue an init before any other request. Configuration may only be
// written while no request is in flight.
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [15:0] request_bytes,
  input  logic [31:0] release_address,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        success,
  output logic [31:0] granted_address,
  output logic [8:0]  free_blocks,
  output logic [12:0] largest_free,
  output logic [12:0] bytes_in_use
);

  ffha_pkg::cmd_t    cmd;
  ffha_pkg::status_t status;

  // sequencer: walks the free list and orders the header updates
  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // header stores, list head, byte total and result register
  ffha_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mode            (mode),
    .request_bytes   (request_bytes),
    .release_address (release_address),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .success         (success),
    .granted_address (granted_address),
    .free_blocks     (free_blocks),
    .largest_free    (largest_free),
    .bytes_in_use    (bytes_in_use)
  );

endmodule
